// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while in reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication helper built on the clocked check
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/bpmc_pkg.sv =====
// shared types, register indexes and mode codes for the button mode cycler
// no dependencies
package bpmc_pkg;

	localparam int TIME_BITS = 32;
	localparam int NOW_W = 32;
	localparam int REG_IDX_W = 3;
	localparam int REG_DATA_W = 16;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [NOW_W-1:0] now_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	typedef logic [REG_DATA_W-1:0] reg_data_t;
	typedef logic [1:0] mode_t;

	localparam reg_idx_t REG_STABLE_SAMPLES = 3'd0;
	localparam reg_idx_t REG_LOCKOUT_MS = 3'd1;
	localparam reg_idx_t REG_MIN_SHORT_GAP_MS = 3'd2;
	localparam reg_idx_t REG_LONG_HOLD_MS = 3'd3;
	localparam reg_idx_t REG_AUTO_SWITCH_DELAY_MS = 3'd4;

	localparam mode_t MODE_SETUP = 2'd0;
	localparam mode_t MODE_GALLERY = 2'd1;
	localparam mode_t MODE_WEATHER_SHOWN = 2'd2;
	localparam mode_t MODE_WEATHER_HIDDEN = 2'd3;

	// wrapping difference of two timestamps
	function automatic time_t elapsed(time_t now, time_t then);
		return now - then;
	endfunction

endpackage

// ===== rtl/core/bpmc_in_if.sv =====
// input channel of the button mode cycler: one poll tick per item
// depends on bpmc_pkg
interface bpmc_in_if;
	import bpmc_pkg::*;

	logic valid;
	logic ready;
	logic raw_level;
	now_t now_ms;
	logic link_ready;
	logic reset_ok;

	modport source (output valid, output raw_level, output now_ms, output link_ready,
		output reset_ok, input ready);
	modport sink (input valid, input raw_level, input now_ms, input link_ready,
		input reset_ok, output ready);
endinterface

// ===== rtl/core/bpmc_out_if.sv =====
// result channel of the button mode cycler: mode and event flags per tick
// depends on bpmc_pkg
interface bpmc_out_if;
	import bpmc_pkg::*;

	logic valid;
	logic ready;
	mode_t mode;
	logic short_event;
	logic long_event;
	logic auto_event;

	modport source (output valid, output mode, output short_event, output long_event,
		output auto_event, input ready);
	modport sink (input valid, input mode, input short_event, input long_event,
		input auto_event, output ready);
endinterface

// ===== rtl/core/button_press_mode_cycler.sv =====
// Button mode cycler. Takes one poll tick per item (raw button level, millisecond
// timestamp, link-ready and reset-ok flags) and returns one result per item: the
// display mode after the tick and short, long and automatic-switch event flags.
// An item is registered on entry and, once the result register is free, is processed
// by a single pass of subtract-and-compare logic into it, so one item is taken every
// cycle while result.ready holds. Registers must be written via wr_en/wr_idx/wr_data
// only while no item is in flight, a rule the block does not enforce. Unknown indexes
// are ignored. Depends on bpmc_pkg, bpmc_in_if, bpmc_out_if and assert_macros.svh.
`include "assert_macros.svh"

module button_press_mode_cycler (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input bpmc_pkg::reg_idx_t wr_idx,
	input bpmc_pkg::reg_data_t wr_data,
	bpmc_in_if.sink sample,
	bpmc_out_if.source result
);
	import bpmc_pkg::*;

	// configuration
	logic [7:0] stable_samples_q;
	logic [15:0] lockout_ms_q;
	logic [15:0] min_short_gap_ms_q;
	logic [15:0] long_hold_ms_q;
	logic [15:0] auto_delay_ms_q;

	// input stage
	logic valid_s1;
	logic raw_s1;
	time_t now_s1;
	logic link_s1;
	logic rst_ok_s1;

	// block state
	logic deb_q;
	logic long_done_q;
	logic [7:0] differ_q;
	time_t press_start_q;
	time_t last_change_q;
	time_t last_short_q;
	logic [1:0] primed_q;
	mode_t mode_q;
	logic link_seen_q;
	logic auto_pending_q;
	time_t link_time_q;

	// result register
	logic out_valid_q;
	mode_t out_mode_q;
	logic out_short_q;
	logic out_long_q;
	logic out_auto_q;

	logic fire_s1;

	// next-state values
	logic [7:0] differ_inc;
	logic differs;
	logic accept;
	logic deb_n;
	logic long_done_n;
	logic [7:0] differ_n;
	time_t press_start_n;
	logic [1:0] primed_n;
	time_t last_short_n;
	logic short_ev;
	logic long_ev;
	logic auto_ev;
	mode_t mode_a;
	mode_t mode_b;
	mode_t mode_n;
	logic pend_a;
	logic pend_n;
	logic seen_n;
	time_t link_time_n;

	assign fire_s1 = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_samples_q <= 8'd4;
			lockout_ms_q <= 16'd60;
			min_short_gap_ms_q <= 16'd150;
			long_hold_ms_q <= 16'd5000;
			auto_delay_ms_q <= 16'd1500;
		end else if (wr_en) begin
			case (wr_idx)
				REG_STABLE_SAMPLES: stable_samples_q <= wr_data[7:0];
				REG_LOCKOUT_MS: lockout_ms_q <= wr_data;
				REG_MIN_SHORT_GAP_MS: min_short_gap_ms_q <= wr_data;
				REG_LONG_HOLD_MS: long_hold_ms_q <= wr_data;
				REG_AUTO_SWITCH_DELAY_MS: auto_delay_ms_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			raw_s1 <= sample.raw_level;
			now_s1 <= time_t'(sample.now_ms);
			link_s1 <= sample.link_ready;
			rst_ok_s1 <= sample.reset_ok;
		end
	end

	always_comb begin
		differs = raw_s1 != deb_q;
		differ_inc = (differ_q == 8'hFF) ? differ_q : differ_q + 8'd1;
		accept = differs && (differ_inc >= stable_samples_q) &&
			(primed_q[0] || elapsed(now_s1, last_change_q) >= time_t'(lockout_ms_q));

		deb_n = deb_q;
		long_done_n = long_done_q;
		press_start_n = press_start_q;
		primed_n = primed_q;
		last_short_n = last_short_q;
		short_ev = 1'b0;
		mode_a = mode_q;
		differ_n = differs ? differ_inc : 8'd0;

		if (accept) begin
			differ_n = 8'd0;
			deb_n = raw_s1;
			primed_n[0] = 1'b0;
			if (raw_s1) begin
				press_start_n = now_s1;
				long_done_n = 1'b0;
			end else if (!long_done_q && (primed_q[1] ||
				elapsed(now_s1, last_short_q) >= time_t'(min_short_gap_ms_q))) begin
				last_short_n = now_s1;
				primed_n[1] = 1'b0;
				mode_a = mode_q + 2'd1;
				short_ev = 1'b1;
			end
		end

		// long hold, measured from the possibly just-updated press start
		long_ev = deb_n && !long_done_n &&
			elapsed(now_s1, press_start_n) >= time_t'(long_hold_ms_q);
		mode_b = mode_a;
		if (long_ev) begin
			long_done_n = 1'b1;
			if (rst_ok_s1) begin
				mode_b = MODE_SETUP;
			end
		end

		// link edge arms the automatic move out of setup
		seen_n = link_seen_q;
		link_time_n = link_time_q;
		pend_a = auto_pending_q;
		pend_n = auto_pending_q;
		mode_n = mode_b;
		auto_ev = 1'b0;
		if (!link_s1) begin
			seen_n = 1'b0;
			pend_n = 1'b0;
		end else begin
			if (!link_seen_q) begin
				seen_n = 1'b1;
				link_time_n = now_s1;
				pend_a = mode_b == MODE_SETUP;
			end
			pend_n = pend_a;
			if (pend_a) begin
				if (mode_b != MODE_SETUP) begin
					pend_n = 1'b0;
				end else if (elapsed(now_s1, link_time_n) >= time_t'(auto_delay_ms_q)) begin
					pend_n = 1'b0;
					mode_n = MODE_GALLERY;
					auto_ev = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q <= 1'b0;
			long_done_q <= 1'b0;
			differ_q <= 8'd0;
			press_start_q <= '0;
			last_change_q <= '0;
			last_short_q <= '0;
			primed_q <= 2'b11;
			mode_q <= MODE_SETUP;
			link_seen_q <= 1'b0;
			auto_pending_q <= 1'b0;
			link_time_q <= '0;
		end else if (fire_s1) begin
			deb_q <= deb_n;
			long_done_q <= long_done_n;
			differ_q <= differ_n;
			press_start_q <= press_start_n;
			if (accept) begin
				last_change_q <= now_s1;
			end
			last_short_q <= last_short_n;
			primed_q <= primed_n;
			mode_q <= mode_n;
			link_seen_q <= seen_n;
			auto_pending_q <= pend_n;
			link_time_q <= link_time_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_mode_q <= mode_n;
			out_short_q <= short_ev;
			out_long_q <= long_ev;
			out_auto_q <= auto_ev;
		end
	end

	assign result.valid = out_valid_q;
	assign result.mode = out_mode_q;
	assign result.short_event = out_short_q;
	assign result.long_event = out_long_q;
	assign result.auto_event = out_auto_q;

	`ASSERT_IMPLIES(a_auto_to_gallery, out_valid_q && out_auto_q, out_mode_q == MODE_GALLERY,
		"automatic switch did not land in gallery")
	`ASSERT_IMPLIES(a_short_on_release, out_valid_q && out_short_q, !deb_q && !out_long_q,
		"short press reported while button held or with long press")
	`ASSERT_IMPLIES(a_long_while_held, out_valid_q && out_long_q, deb_q && long_done_q,
		"long press reported without a held button")
	`ASSERT_CLK(a_state_holds, !fire_s1 |=> $stable(mode_q) && $stable(deb_q),
		"state changed without an item processed")
	`ASSERT_CLK(a_item_kept, valid_s1 && !fire_s1 |=> valid_s1,
		"item dropped from input stage")

endmodule

// ===== tb/button_press_mode_cycler_tb.sv =====
// self-checking testbench for button_press_mode_cycler: poll ticks in, mode and events out
// needs bpmc_pkg, bpmc_in_if, bpmc_out_if and the block itself from the rtl
module button_press_mode_cycler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bpmc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RX_HOLD_CYCLES = 300;
	localparam reg_idx_t REG_UNUSED_LO = REG_AUTO_SWITCH_DELAY_MS + 3'd1;
	localparam reg_idx_t REG_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic raw;
		now_t now;
		logic link;
		logic rok;
	} tick_t;

	typedef struct packed {
		mode_t mode;
		logic short_ev;
		logic long_ev;
		logic auto_ev;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	reg_idx_t wr_idx;
	reg_data_t wr_data;

	bpmc_in_if smp ();
	bpmc_out_if res ();

	button_press_mode_cycler i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_idx(wr_idx),
		.wr_data(wr_data),
		.sample(smp),
		.result(res)
	);

	tick_t ticks_to_send[$];
	outcome_t outcomes_due[$];
	int errors = 0;
	int cycle_cnt = 0;
	int unsigned ticks_queued = 0;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic rx_hold_req;
	logic rx_hold_done;
	int rx_hold_left;

	// stimulus time base and link level
	now_t clock_ms = 32'd0;
	int unsigned step_max = 40;
	logic link_lvl = 1'b0;

	// predictor copy of the registers
	logic [7:0] cfg_stable = 8'd4;
	logic [15:0] cfg_lockout = 16'd60;
	logic [15:0] cfg_gap = 16'd150;
	logic [15:0] cfg_long = 16'd5000;
	logic [15:0] cfg_auto = 16'd1500;

	// predictor state
	logic deb_level = 1'b0;
	logic long_fired = 1'b0;
	logic [7:0] diff_cnt = 8'd0;
	time_t press_t = '0;
	time_t change_t = '0;
	time_t short_t = '0;
	logic lock_primed = 1'b1;
	logic gap_primed = 1'b1;
	mode_t cur_mode = MODE_SETUP;
	logic link_was_seen = 1'b0;
	logic auto_armed = 1'b0;
	time_t link_t = '0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic outcome_t mode_step(tick_t t);
		outcome_t o;
		time_t dt;
		o = '0;
		if (t.raw == deb_level) begin
			diff_cnt = 8'd0;
		end else begin
			if (diff_cnt != 8'hFF)
				diff_cnt = diff_cnt + 8'd1;
			dt = t.now - change_t;
			if (diff_cnt >= cfg_stable && (lock_primed || dt >= cfg_lockout)) begin
				diff_cnt = 8'd0;
				deb_level = t.raw;
				change_t = t.now;
				lock_primed = 1'b0;
				if (deb_level) begin
					press_t = t.now;
					long_fired = 1'b0;
				end else begin
					dt = t.now - short_t;
					if (!long_fired && (gap_primed || dt >= cfg_gap)) begin
						short_t = t.now;
						gap_primed = 1'b0;
						cur_mode = cur_mode + 2'd1;
						o.short_ev = 1'b1;
					end
				end
			end
		end
		dt = t.now - press_t;
		if (deb_level && !long_fired && dt >= cfg_long) begin
			long_fired = 1'b1;
			o.long_ev = 1'b1;
			if (t.rok)
				cur_mode = MODE_SETUP;
		end
		if (!t.link) begin
			link_was_seen = 1'b0;
			auto_armed = 1'b0;
		end else begin
			if (!link_was_seen) begin
				link_was_seen = 1'b1;
				link_t = t.now;
				auto_armed = (cur_mode == MODE_SETUP);
			end
			if (auto_armed) begin
				dt = t.now - link_t;
				if (cur_mode != MODE_SETUP) begin
					auto_armed = 1'b0;
				end else if (dt >= cfg_auto) begin
					auto_armed = 1'b0;
					cur_mode = MODE_GALLERY;
					o.auto_ev = 1'b1;
				end
			end
		end
		o.mode = cur_mode;
		return o;
	endfunction

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive
		tick_t nxt;
		if (!arst_n) begin
			smp.valid <= 1'b0;
		end else begin
			if (smp.valid && smp.ready)
				outcomes_due.push_back(mode_step({smp.raw_level, smp.now_ms, smp.link_ready,
					smp.reset_ok}));
			if (!smp.valid || smp.ready) begin
				if (ticks_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = ticks_to_send.pop_front();
					smp.valid <= 1'b1;
					smp.raw_level <= nxt.raw;
					smp.now_ms <= nxt.now;
					smp.link_ready <= nxt.link;
					smp.reset_ok <= nxt.rok;
				end else begin
					smp.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t exp;
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				if (outcomes_due.size() == 0) begin
					flag_error($sformatf("unexpected result: mode %0d short %0b long %0b auto %0b",
						res.mode, res.short_event, res.long_event, res.auto_event));
				end else begin
					exp = outcomes_due.pop_front();
					if (res.mode !== exp.mode || res.short_event !== exp.short_ev ||
						res.long_event !== exp.long_ev || res.auto_event !== exp.auto_ev)
						flag_error($sformatf({"mismatch: expected mode %0d short %0b long %0b auto %0b,",
							" got mode %0d short %0b long %0b auto %0b"},
							exp.mode, exp.short_ev, exp.long_ev, exp.auto_ev,
							res.mode, res.short_event, res.long_event, res.auto_event));
				end
			end
			res.ready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// one long receiver hold-off, timed here so the sender keeps offering items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold_left <= 0;
			rx_hold_done <= 1'b0;
		end else if (rx_hold_req && !rx_hold_done) begin
			rx_hold_left <= RX_HOLD_CYCLES;
			rx_hold_done <= 1'b1;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("button_press_mode_cycler_tb failed");
			$finish;
		end
	end

	task automatic queue_tick(logic raw, now_t now, logic link, logic rok);
		ticks_to_send.push_back({raw, now, link, rok});
		ticks_queued++;
	endtask

	// random time step: mostly small, now and then a jump of up to 70000 ms or a random timestamp
	task automatic push_tick(logic raw);
		int unsigned r;
		r = $urandom_range(0, 199);
		if (r == 0)
			clock_ms = $urandom;
		else if (r < 5)
			clock_ms = clock_ms + $urandom_range(0, 70000);
		else
			clock_ms = clock_ms + $urandom_range(1, step_max);
		if ($urandom_range(0, 29) == 0)
			link_lvl = !link_lvl;
		queue_tick(raw, clock_ms, link_lvl, 1'($urandom_range(0, 1)));
	endtask

	// press with contact bounce at both ends, then a release
	task automatic push_press(int unsigned hold_max);
		int unsigned nb;
		nb = $urandom_range(0, 3);
		for (int i = 0; i < nb; i++)
			push_tick(i % 2 == 0);
		repeat ($urandom_range(1, hold_max))
			push_tick(1'b1);
		nb = $urandom_range(0, 3);
		for (int i = 0; i < nb; i++)
			push_tick(i % 2 != 0);
		repeat ($urandom_range(1, hold_max))
			push_tick(1'b0);
	endtask

	task automatic fill_random(int unsigned n, int unsigned hold_max);
		int unsigned first;
		first = ticks_queued;
		while (ticks_queued - first < n) begin
			if ($urandom_range(0, 9) < 7)
				push_press(hold_max);
			else
				repeat ($urandom_range(1, 12))
					push_tick(1'($urandom_range(0, 1)));
		end
	endtask

	// block idle: nothing left to send, nothing in flight
	// checked between edges so the driver's updates have settled
	task automatic wait_idle();
		@(negedge clk);
		while (ticks_to_send.size() != 0 || smp.valid || outcomes_due.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, reg_data_t val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= val;
		case (idx)
			REG_STABLE_SAMPLES: cfg_stable = val[7:0];
			REG_LOCKOUT_MS: cfg_lockout = val;
			REG_MIN_SHORT_GAP_MS: cfg_gap = val;
			REG_LONG_HOLD_MS: cfg_long = val;
			REG_AUTO_SWITCH_DELAY_MS: cfg_auto = val;
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_config(reg_data_t stable, reg_data_t lockout, reg_data_t gap,
		reg_data_t long_hold, reg_data_t auto_delay);
		write_reg(REG_STABLE_SAMPLES, stable);
		write_reg(REG_LOCKOUT_MS, lockout);
		write_reg(REG_MIN_SHORT_GAP_MS, gap);
		write_reg(REG_LONG_HOLD_MS, long_hold);
		write_reg(REG_AUTO_SWITCH_DELAY_MS, auto_delay);
	endtask

	task automatic run_phase(int unsigned n, int unsigned hold_max, int unsigned steps,
		int unsigned sidle, int unsigned rstall);
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		step_max = steps;
		fill_random(n, hold_max);
		wait_idle();
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_idx = '0;
		wr_data = '0;
		smp.valid = 1'b0;
		smp.raw_level = 1'b0;
		smp.now_ms = '0;
		smp.link_ready = 1'b0;
		smp.reset_ok = 1'b0;
		res.ready = 1'b0;
		rx_hold_req = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, timers still primed: first change and first short press pass at once
		for (int i = 0; i < 4; i++)
			queue_tick(1'b1, 32'd100 + i, 1'b0, 1'b0);
		for (int i = 0; i < 4; i++)
			queue_tick(1'b0, 32'd200 + i, 1'b0, 1'b0);
		// inside the lockout, then link rises outside setup
		for (int i = 0; i < 4; i++)
			queue_tick(1'b1, 32'd250 + i, 1'b1, 1'b0);
		queue_tick(1'b1, 32'd270, 1'b1, 1'b1);
		// release too soon after the last short press
		for (int i = 0; i < 4; i++)
			queue_tick(1'b0, 32'd300 + i, 1'b1, 1'b0);
		queue_tick(1'b0, 32'd340, 1'b1, 1'b0);
		wait_idle();

		// unknown indexes ignored, wide value cut to eight bits giving zero stable samples
		for (int i = REG_UNUSED_LO; i <= REG_UNUSED_HI; i++)
			write_reg(reg_idx_t'(i), 16'hFFFF);
		set_config(16'h0100, 16'd0, 16'd0, 16'd0, 16'd0);
		queue_tick(1'b0, 32'hFFFF_FFF0, 1'b0, 1'b0);
		// long press on acceptance and link edge in the same tick
		queue_tick(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
		queue_tick(1'b0, 32'h0000_0000, 1'b1, 1'b0);
		queue_tick(1'b1, 32'h0000_0001, 1'b1, 1'b0);
		queue_tick(1'b0, 32'h0000_0002, 1'b0, 1'b1);
		queue_tick(1'b1, 32'h0000_0003, 1'b0, 1'b1);
		queue_tick(1'b0, 32'h0000_0004, 1'b1, 1'b0);
		wait_idle();

		// no idling, with one long receiver hold-off while the queue still holds 200 items
		set_config(16'd2, 16'd20, 16'd100, 16'd400, 16'd300);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		step_max = 40;
		fill_random(300, 40);
		while (ticks_to_send.size() > 200)
			@(posedge clk);
		rx_hold_req <= 1'b1;
		wait_idle();

		set_config(16'd1, 16'd0, 16'd0, 16'd1, 16'd0);
		run_phase(250, 30, 30, 85, 0);

		// timestamps cross the wrap point early in this phase
		set_config(16'd5, 16'd80, 16'd300, 16'd800, 16'd1000);
		clock_ms = 32'hFFFF_F000;
		run_phase(300, 40, 40, 0, 85);

		// widest settings: the sample counter saturates inside the lockout
		set_config(16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_phase(300, 320, 300, 12, 12);

		set_config(16'd3, 16'd30, 16'd200, 16'd600, 16'd500);
		run_phase(400, 40, 30, 12, 12);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && outcomes_due.size() == 0)
			$display("button_press_mode_cycler_tb passed");
		else
			$display("button_press_mode_cycler_tb failed");
		$finish;
	end

endmodule
